/* src/tlpq_pkg.sv */
// Shared types, constants and command codes of the tree path query unit.
package tlpq_pkg;

  localparam int NODE_COUNT_DEF  = 16384;
  localparam int LIFT_LEVELS_DEF = 14;

  localparam int NODE_IN_W = 14;
  localparam int WEIGHT_W  = 17;
  localparam int KPOS_W    = 15;
  localparam int DEPTH_W   = 14;
  localparam int DIST_W    = 31;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  localparam logic KIND_DIST = 1'b0;
  localparam logic KIND_KTH  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DIST  = 2'd1,
    OP_KTH   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLR,
    CMD_RD_A,
    CMD_RD_B,
    CMD_ADD_BASE,
    CMD_ADD_RD,
    CMD_ADD_CAP,
    CMD_ADD_WR,
    CMD_Q_CAPA_RDB,
    CMD_Q_CAPB,
    CMD_Q_ORDER,
    CMD_L_RD,
    CMD_L_CAP,
    CMD_D_RD_A,
    CMD_D_CAPA_RDB,
    CMD_D_CAPB,
    CMD_EQ_P,
    CMD_P_RD,
    CMD_P_CAP,
    CMD_FIN,
    CMD_K_RD,
    CMD_K_CAP,
    CMD_OUT
  } dp_cmd_t;

  typedef enum logic [2:0] {
    LV_KEEP,
    LV_ZERO,
    LV_INC,
    LV_DEC,
    LV_TOP
  } lv_op_t;

  typedef struct packed {
    dp_cmd_t code;
    lv_op_t  lv;
  } dp_ctl_t;

  typedef struct packed {
    op_t  op;
    logic add_ok;
    logic step_bit;
    logic lvl_last;
    logic lvl_zero;
    logic add_last;
    logic anc_diff;
    logic walk_eq;
    logic kth_go;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/tlpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tlpq_ctrl.sv */
// Sequencer that steps the datapath through add, query and clear operations.
module tlpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tlpq_pkg::dp_stat_t  stat,
  output tlpq_pkg::dp_ctl_t   ctl
);

  typedef enum logic [22:0] {
    S_CLR      = 23'd1 << 0,
    S_IDLE     = 23'd1 << 1,
    S_ADD_CHK  = 23'd1 << 2,
    S_ADD_BASE = 23'd1 << 3,
    S_ADD_RD   = 23'd1 << 4,
    S_ADD_CAP  = 23'd1 << 5,
    S_ADD_WR   = 23'd1 << 6,
    S_Q_RDA    = 23'd1 << 7,
    S_Q_CAPA   = 23'd1 << 8,
    S_Q_CAPB   = 23'd1 << 9,
    S_Q_ORD    = 23'd1 << 10,
    S_L_CHK    = 23'd1 << 11,
    S_L_CAP    = 23'd1 << 12,
    S_L_END    = 23'd1 << 13,
    S_D_CHK    = 23'd1 << 14,
    S_D_CA     = 23'd1 << 15,
    S_D_CB     = 23'd1 << 16,
    S_P_RD     = 23'd1 << 17,
    S_P_CAP    = 23'd1 << 18,
    S_FIN      = 23'd1 << 19,
    S_K_RD     = 23'd1 << 20,
    S_K_CAP    = 23'd1 << 21,
    S_OUT      = 23'd1 << 22
  } state_t;

  state_t state, state_next;
  logic   kth_phase, kth_phase_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      kth_phase <= 1'b0;
    end else begin
      state     <= state_next;
      kth_phase <= kth_phase_next;
    end
  end

  always_comb begin
    state_next     = state;
    kth_phase_next = kth_phase;
    ctl.code       = tlpq_pkg::CMD_NONE;
    ctl.lv         = tlpq_pkg::LV_KEEP;
    case (state)
      S_CLR: begin
        ctl.code = tlpq_pkg::CMD_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.code = tlpq_pkg::CMD_LOAD;
          kth_phase_next = 1'b0;
          state_next = S_Q_RDA;
        end
      end
      S_ADD_CHK: begin
        if (stat.add_ok) begin
          ctl.code   = tlpq_pkg::CMD_RD_B;
          state_next = S_ADD_BASE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADD_BASE: begin
        ctl.code   = tlpq_pkg::CMD_ADD_BASE;
        ctl.lv     = tlpq_pkg::LV_ZERO;
        state_next = S_ADD_RD;
      end
      S_ADD_RD: begin
        ctl.code   = tlpq_pkg::CMD_ADD_RD;
        state_next = S_ADD_CAP;
      end
      S_ADD_CAP: begin
        ctl.code = tlpq_pkg::CMD_ADD_CAP;
        if (stat.add_last) begin
          state_next = S_ADD_WR;
        end else begin
          ctl.lv     = tlpq_pkg::LV_INC;
          state_next = S_ADD_RD;
        end
      end
      S_ADD_WR: begin
        ctl.code   = tlpq_pkg::CMD_ADD_WR;
        state_next = S_IDLE;
      end
      S_Q_RDA: begin
        // The op code is only known once the beat has been loaded.
        case (stat.op)
          tlpq_pkg::OP_ADD:   state_next = S_ADD_CHK;
          tlpq_pkg::OP_CLEAR: state_next = S_CLR;
          default: begin
            ctl.code   = tlpq_pkg::CMD_RD_A;
            state_next = S_Q_CAPA;
          end
        endcase
      end
      S_Q_CAPA: begin
        ctl.code   = tlpq_pkg::CMD_Q_CAPA_RDB;
        state_next = S_Q_CAPB;
      end
      S_Q_CAPB: begin
        ctl.code   = tlpq_pkg::CMD_Q_CAPB;
        state_next = S_Q_ORD;
      end
      S_Q_ORD: begin
        ctl.code   = tlpq_pkg::CMD_Q_ORDER;
        ctl.lv     = tlpq_pkg::LV_ZERO;
        state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (stat.step_bit) begin
          ctl.code   = tlpq_pkg::CMD_L_RD;
          state_next = S_L_CAP;
        end else if (stat.lvl_last) begin
          state_next = S_L_END;
        end else begin
          ctl.lv = tlpq_pkg::LV_INC;
        end
      end
      S_L_CAP: begin
        ctl.code = tlpq_pkg::CMD_L_CAP;
        if (stat.lvl_last) begin
          state_next = S_L_END;
        end else begin
          ctl.lv     = tlpq_pkg::LV_INC;
          state_next = S_L_CHK;
        end
      end
      S_L_END: begin
        if (kth_phase) begin
          state_next = S_OUT;
        end else if (stat.walk_eq) begin
          ctl.code   = tlpq_pkg::CMD_EQ_P;
          state_next = S_FIN;
        end else begin
          ctl.lv     = tlpq_pkg::LV_TOP;
          state_next = S_D_CHK;
        end
      end
      S_D_CHK: begin
        if (stat.anc_diff) begin
          ctl.code   = tlpq_pkg::CMD_D_RD_A;
          state_next = S_D_CA;
        end else if (stat.lvl_zero) begin
          state_next = S_P_RD;
        end else begin
          ctl.lv = tlpq_pkg::LV_DEC;
        end
      end
      S_D_CA: begin
        ctl.code   = tlpq_pkg::CMD_D_CAPA_RDB;
        state_next = S_D_CB;
      end
      S_D_CB: begin
        ctl.code = tlpq_pkg::CMD_D_CAPB;
        if (stat.lvl_zero) begin
          state_next = S_P_RD;
        end else begin
          ctl.lv     = tlpq_pkg::LV_DEC;
          state_next = S_D_CHK;
        end
      end
      S_P_RD: begin
        ctl.code   = tlpq_pkg::CMD_P_RD;
        state_next = S_P_CAP;
      end
      S_P_CAP: begin
        ctl.code   = tlpq_pkg::CMD_P_CAP;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.code = tlpq_pkg::CMD_FIN;
        if (stat.kth_go) begin
          kth_phase_next = 1'b1;
          state_next     = S_K_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_K_RD: begin
        ctl.code   = tlpq_pkg::CMD_K_RD;
        state_next = S_K_CAP;
      end
      S_K_CAP: begin
        ctl.code   = tlpq_pkg::CMD_K_CAP;
        ctl.lv     = tlpq_pkg::LV_ZERO;
        state_next = S_L_CHK;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.code   = tlpq_pkg::CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

/* src/tlpq_dp.sv */
// Datapath: node table memory, walker registers, result arithmetic and output register.
module tlpq_dp #(
  parameter int NODE_COUNT  = tlpq_pkg::NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = tlpq_pkg::LIFT_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tlpq_pkg::dp_ctl_t                ctl,
  output tlpq_pkg::dp_stat_t               stat,
  input  logic [tlpq_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [tlpq_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tlpq_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tuser
);

  localparam int NW       = $clog2(NODE_COUNT);
  localparam int LVW      = $clog2(LIFT_LEVELS);
  localparam int DEPTH_W  = tlpq_pkg::DEPTH_W;
  localparam int DIST_W   = tlpq_pkg::DIST_W;
  localparam int ANC_W    = LIFT_LEVELS * NW;
  localparam int DEP_LSB  = ANC_W;
  localparam int DIST_LSB = ANC_W + DEPTH_W;
  localparam int ROW_W    = ANC_W + DEPTH_W + DIST_W;

  // Input beat fields.
  logic [tlpq_pkg::NODE_IN_W-1:0] raw_a, raw_b;
  logic [tlpq_pkg::WEIGHT_W-1:0]  in_w;
  logic [tlpq_pkg::KPOS_W-1:0]    in_k;
  logic [16:0]                    raw_a_ext, raw_b_ext;
  logic                           a_in, b_in;

  assign raw_a     = s_tdata[13:0];
  assign raw_b     = s_tdata[27:14];
  assign in_w      = s_tdata[44:28];
  assign in_k      = s_tdata[59:45];
  assign raw_a_ext = {3'b000, raw_a};
  assign raw_b_ext = {3'b000, raw_b};
  assign a_in      = raw_a_ext < 17'(NODE_COUNT);
  assign b_in      = raw_b_ext < 17'(NODE_COUNT);

  // Registers.
  tlpq_pkg::op_t               op_q;
  logic                        add_ok;
  logic [NW-1:0]               na, nb;
  logic [tlpq_pkg::WEIGHT_W-1:0] wt;
  logic [tlpq_pkg::KPOS_W-1:0] kpos;
  logic [ROW_W-1:0]            row_a, row_b, new_row;
  logic [NW-1:0]               node_wa, node_wb, pend;
  logic [DEPTH_W-1:0]          dep_a0, dep_b0, p_dep;
  logic [DIST_W-1:0]           dist_a0, dist_b0, p_dist;
  logic [LVW-1:0]              lvl;
  logic [LIFT_LEVELS-1:0]      steps;
  logic [NW-1:0]               clr_cnt;
  logic                        kth_bad;

  // Memory ports.
  logic             ram_we, ram_re;
  logic [NW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, rdata;

  tlpq_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Field views.
  logic [NW-1:0]      a_anc_l, b_anc_l, a_anc_0, new_anc_l, rd_anc_l;
  logic [DEPTH_W-1:0] a_dep, b_dep, rd_dep, dep_new;
  logic [DIST_W-1:0]  rd_dist, dist_new;
  logic [31:0]        dist_sum;

  assign a_anc_l   = row_a[int'(lvl)*NW +: NW];
  assign b_anc_l   = row_b[int'(lvl)*NW +: NW];
  assign a_anc_0   = row_a[NW-1:0];
  assign new_anc_l = new_row[int'(lvl)*NW +: NW];
  assign rd_anc_l  = rdata[int'(lvl)*NW +: NW];
  assign a_dep     = row_a[DEP_LSB +: DEPTH_W];
  assign b_dep     = row_b[DEP_LSB +: DEPTH_W];
  assign rd_dep    = rdata[DEP_LSB +: DEPTH_W];
  assign rd_dist   = rdata[DIST_LSB +: DIST_W];
  assign dep_new   = (rd_dep == tlpq_pkg::DEPTH_MAX) ? rd_dep : rd_dep + 1'b1;
  assign dist_sum  = {1'b0, rd_dist} + {15'd0, wt};
  assign dist_new  = dist_sum[31] ? tlpq_pkg::DIST_MAX : dist_sum[30:0];

  // Swap order and depth difference for equalizing.
  logic               a_shallow;
  logic [DEPTH_W-1:0] dep_diff;
  logic [15:0]        diff16;

  assign a_shallow = a_dep < b_dep;
  assign dep_diff  = a_shallow ? (b_dep - a_dep) : (a_dep - b_dep);
  assign diff16    = {2'b00, dep_diff};

  // Distance answer.
  logic [32:0]       dsum;
  logic [DIST_W-1:0] dist_res;

  assign dsum = {2'b00, dist_a0} + {2'b00, dist_b0} - {1'b0, p_dist, 1'b0};
  always_comb begin
    if (dsum[32]) begin
      dist_res = '0;
    end else if (dsum[31]) begin
      dist_res = tlpq_pkg::DIST_MAX;
    end else begin
      dist_res = dsum[30:0];
    end
  end

  // Kth answer: position check and the start of the final walk.
  logic [DEPTH_W-1:0] xd, yd, ky;
  logic [15:0]        len1;
  logic [14:0]        km, kmx;
  logic               bad, use_a;
  logic [15:0]        kst16;

  assign xd    = (dep_a0 > p_dep) ? dep_a0 - p_dep : '0;
  assign yd    = (dep_b0 > p_dep) ? dep_b0 - p_dep : '0;
  assign len1  = {2'b00, xd} + {2'b00, yd} + 16'd1;
  assign bad   = (kpos == '0) || ({1'b0, kpos} > len1);
  assign km    = kpos - 15'd1;
  assign use_a = km <= {1'b0, xd};
  assign kmx   = km - {1'b0, xd};
  assign ky    = yd - kmx[DEPTH_W-1:0];
  assign kst16 = use_a ? {1'b0, km} : {2'b00, ky};

  // Status to the sequencer.
  assign stat.op       = op_q;
  assign stat.add_ok   = add_ok;
  assign stat.step_bit = steps[lvl];
  assign stat.lvl_last = lvl == LVW'(LIFT_LEVELS - 1);
  assign stat.lvl_zero = lvl == '0;
  assign stat.add_last = lvl == LVW'(LIFT_LEVELS - 2);
  assign stat.anc_diff = a_anc_l != b_anc_l;
  assign stat.walk_eq  = node_wa == node_wb;
  assign stat.kth_go   = (op_q == tlpq_pkg::OP_KTH) && !bad;
  assign stat.clr_last = clr_cnt == NW'(NODE_COUNT - 1);
  assign stat.out_free = !m_tvalid || m_tready;

  // Memory access per command.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = na;
    ram_wdata = new_row;
    ram_re    = 1'b0;
    ram_raddr = na;
    case (ctl.code)
      tlpq_pkg::CMD_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      tlpq_pkg::CMD_ADD_WR: ram_we = 1'b1;
      tlpq_pkg::CMD_RD_A:   ram_re = 1'b1;
      tlpq_pkg::CMD_RD_B, tlpq_pkg::CMD_Q_CAPA_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = nb;
      end
      tlpq_pkg::CMD_ADD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = new_anc_l;
      end
      tlpq_pkg::CMD_L_RD, tlpq_pkg::CMD_D_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = a_anc_l;
      end
      tlpq_pkg::CMD_D_CAPA_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = node_wb;
      end
      tlpq_pkg::CMD_P_RD: begin
        ram_re    = 1'b1;
        ram_raddr = a_anc_0;
      end
      tlpq_pkg::CMD_K_RD: begin
        ram_re    = 1'b1;
        ram_raddr = node_wa;
      end
      default: ram_re = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q     <= tlpq_pkg::OP_ADD;
      lvl      <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.code == tlpq_pkg::CMD_LOAD) begin
        op_q <= tlpq_pkg::op_t'(s_tuser);
      end
      if (ctl.code == tlpq_pkg::CMD_CLR) begin
        clr_cnt <= stat.clr_last ? '0 : clr_cnt + 1'b1;
      end
      case (ctl.lv)
        tlpq_pkg::LV_ZERO: lvl <= '0;
        tlpq_pkg::LV_INC:  lvl <= lvl + 1'b1;
        tlpq_pkg::LV_DEC:  lvl <= lvl - 1'b1;
        tlpq_pkg::LV_TOP:  lvl <= LVW'(LIFT_LEVELS - 1);
        default:           lvl <= lvl;
      endcase
      if (ctl.code == tlpq_pkg::CMD_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (ctl.code)
      tlpq_pkg::CMD_LOAD: begin
        na     <= a_in ? raw_a_ext[NW-1:0] : '0;
        nb     <= b_in ? raw_b_ext[NW-1:0] : '0;
        add_ok <= a_in && b_in && (raw_a > 14'd1) && (raw_a != raw_b);
        wt     <= in_w;
        kpos   <= in_k;
      end
      tlpq_pkg::CMD_ADD_BASE: begin
        new_row <= {dist_new, dep_new, {(ANC_W - NW){1'b0}}, nb};
      end
      tlpq_pkg::CMD_ADD_RD: pend <= new_anc_l;
      tlpq_pkg::CMD_ADD_CAP: begin
        // A walk back onto the node being added sees its fresh entries.
        new_row[(int'(lvl) + 1)*NW +: NW] <= (pend == na) ? new_anc_l : rd_anc_l;
      end
      tlpq_pkg::CMD_Q_CAPA_RDB: begin
        row_a   <= rdata;
        node_wa <= na;
        dep_a0  <= rd_dep;
        dist_a0 <= rd_dist;
      end
      tlpq_pkg::CMD_Q_CAPB: begin
        row_b   <= rdata;
        node_wb <= nb;
        dep_b0  <= rd_dep;
        dist_b0 <= rd_dist;
      end
      tlpq_pkg::CMD_Q_ORDER: begin
        if (a_shallow) begin
          row_a   <= row_b;
          row_b   <= row_a;
          node_wa <= node_wb;
          node_wb <= node_wa;
        end
        steps <= diff16[LIFT_LEVELS-1:0];
      end
      tlpq_pkg::CMD_L_RD: node_wa <= a_anc_l;
      tlpq_pkg::CMD_L_CAP, tlpq_pkg::CMD_D_CAPA_RDB, tlpq_pkg::CMD_K_CAP: row_a <= rdata;
      tlpq_pkg::CMD_D_RD_A: begin
        node_wa <= a_anc_l;
        node_wb <= b_anc_l;
      end
      tlpq_pkg::CMD_D_CAPB: row_b <= rdata;
      tlpq_pkg::CMD_EQ_P: begin
        p_dep  <= a_dep;
        p_dist <= row_a[DIST_LSB +: DIST_W];
      end
      tlpq_pkg::CMD_P_CAP: begin
        p_dep  <= rd_dep;
        p_dist <= rd_dist;
      end
      tlpq_pkg::CMD_FIN: begin
        kth_bad <= bad;
        steps   <= kst16[LIFT_LEVELS-1:0];
        node_wa <= use_a ? na : nb;
      end
      tlpq_pkg::CMD_OUT: begin
        m_tuser <= (op_q == tlpq_pkg::OP_KTH) ? tlpq_pkg::KIND_KTH : tlpq_pkg::KIND_DIST;
        if (op_q == tlpq_pkg::OP_KTH) begin
          m_tdata <= {2'b00, kth_bad,
                      kth_bad ? 14'd0 : 14'({{(17 - NW){1'b0}}, node_wa}),
                      {DIST_W{1'b0}}};
        end else begin
          m_tdata <= {2'b00, 1'b0, 14'd0, dist_res};
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/tree_lca_path_query_unit.sv */
// Top level of the tree path query unit: sequencer plus datapath.
//
// Input beats arrive on s_tvalid/s_tready with the operation in s_tuser:
// add node, distance query, kth node query, or clear tree. Adds and clears
// give no output beat; each query gives exactly one beat on m_tvalid/m_tready.
// Nodes, depths and root distances live in one table memory of NODE_COUNT
// rows, one row per node, read one row per cycle with registered read data.
// After its beat an add keeps s_tready low while it builds and writes the new
// row, and an ignored add while it is checked. A query runs an equalizing
// walk, a common ancestor descent, then for kth one more walk, all through
// the single read port of that memory. After reset, and after a clear
// operation, a sweep writes every row to zero while s_tready stays low.
// The result sits in an output register; the block takes a new input beat
// while it waits, and a query finishing against a stalled receiver holds
// its result until the earlier beat has been taken.
module tree_lca_path_query_unit #(
  parameter int NODE_COUNT  = tlpq_pkg::NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = tlpq_pkg::LIFT_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // node_a[13:0], node_b[27:14], edge_weight[44:28], kth_position[59:45]
  input  logic [tlpq_pkg::S_TDATA_W-1:0] s_tdata,
  // operation[1:0]
  input  logic [tlpq_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // answer_distance[30:0], answer_node[44:31], out_of_range[45]
  output logic [tlpq_pkg::M_TDATA_W-1:0] m_tdata,
  // answer_kind[0]
  output logic                           m_tuser
);

  tlpq_pkg::dp_ctl_t  ctl;
  tlpq_pkg::dp_stat_t stat;

  tlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tlpq_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* src/tlpq_checker.sv */
// Port-level checks of the tree path query unit and their binding.
module tlpq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tlpq_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_dist_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tlpq_pkg::KIND_DIST) |-> m_tdata[45:31] == '0)
    else $error("distance answer carries node or range flag");

  a_kth_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tlpq_pkg::KIND_KTH) |-> m_tdata[30:0] == '0)
    else $error("kth answer carries a distance");

  a_oor_node: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[45] |-> m_tdata[44:31] == '0)
    else $error("out of range answer carries a node");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block not quiet after reset");

endmodule

bind tree_lca_path_query_unit tlpq_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
